// ===== hw/rtl/gpt_header_validator_defines.svh =====
// gpt_header_validator_defines.svh: assertion macros for the gpt header validator
// used by the modules under hw/rtl that carry concurrent checks
// each macro expects clk and rst_n in scope
`ifndef GPT_HEADER_VALIDATOR_DEFINES_SVH
`define GPT_HEADER_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GPTHV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpthv: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define GPTHV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpthv: next-cycle check failed");
`else
`define GPTHV_ASSERT_IMP(name, ante, cons)
`define GPTHV_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/gpthv_pkg.sv =====
// gpthv_pkg: types, constants and helper functions of the gpt header validator
// no dependencies; used by gpthv_accum, gpthv_check and gpt_header_validator
`timescale 1ns / 1ps

package gpthv_pkg;

    // block geometry
    localparam int          BLOCK_BYTES_DEF = 512;
    localparam int          OFFSET_W        = 13;
    localparam logic [12:0] OFFSET_MAX      = 13'd8191;

    // header layout (byte offsets)
    localparam logic [12:0] OFS_SIG       = 13'd0;
    localparam logic [12:0] OFS_HDR_SIZE  = 13'd12;
    localparam logic [12:0] OFS_HDR_CRC   = 13'd16;
    localparam logic [12:0] OFS_CRC_END   = 13'd20;
    localparam logic [12:0] OFS_MY_LBA    = 13'd24;
    localparam logic [12:0] OFS_ALT_LBA   = 13'd32;
    localparam logic [12:0] OFS_FIRST_LBA = 13'd40;
    localparam logic [12:0] OFS_LAST_LBA  = 13'd48;
    localparam logic [12:0] OFS_ENT_LBA   = 13'd72;
    localparam logic [12:0] OFS_ENT_CNT   = 13'd80;
    localparam logic [12:0] OFS_ENT_SIZE  = 13'd84;
    localparam logic [12:0] OFS_ENT_CRC   = 13'd88;

    // "EFI PART" read little endian
    localparam logic [63:0] SIG_EFI_PART  = 64'h5452_4150_2049_4645;
    localparam logic [31:0] MIN_HDR_SIZE  = 32'd20;

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic CFG_HEADER_LBA    = 1'b0;
    localparam logic CFG_DISK_LAST_LBA = 1'b1;

    // verdict codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_CRC_SIZE  = 3'd2;
    localparam logic [2:0] ERR_MY_LBA    = 3'd3;
    localparam logic [2:0] ERR_FIRST_LBA = 3'd4;
    localparam logic [2:0] ERR_LAST_LBA  = 3'd5;
    localparam logic [2:0] ERR_ENTRY_LBA = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gpthv_in_t;

    typedef struct packed {
        logic        header_ok;
        logic [2:0]  error_code;
        logic [63:0] alt_hdr_lba;
        logic [63:0] first_use_lba;
        logic [63:0] last_use_lba;
        logic [63:0] entry_array_lba;
        logic [31:0] entry_count;
        logic [31:0] entry_size;
        logic [31:0] entry_array_crc;
    } gpthv_out_t;

    // frozen header state handed from the accumulator to the checker
    typedef struct packed {
        logic [63:0] signature;
        logic [31:0] hdr_size;
        logic [31:0] hdr_crc;
        logic [31:0] calc_crc;
        logic [12:0] byte_count;
        logic [63:0] my_lba;
        logic [63:0] alt_lba;
        logic [63:0] first_lba;
        logic [63:0] last_lba;
        logic [63:0] ent_lba;
        logic [31:0] ent_count;
        logic [31:0] ent_size;
        logic [31:0] ent_crc;
    } gpthv_snap_t;

    // one byte through the reflected crc-32
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // drop a byte into its lane of a 64-bit little endian field
    function automatic logic [63:0] put64(input logic [63:0] f, input logic [12:0] o,
                                          input logic [12:0] start, input logic [7:0] b);
        logic [63:0] r;
        r = f;
        for (int i = 0; i < 8; i++) begin
            if (o == start + 13'(i)) begin
                r[i*8 +: 8] = b;
            end
        end
        return r;
    endfunction

    // drop a byte into its lane of a 32-bit little endian field
    function automatic logic [31:0] put32(input logic [31:0] f, input logic [12:0] o,
                                          input logic [12:0] start, input logic [7:0] b);
        logic [31:0] r;
        r = f;
        for (int i = 0; i < 4; i++) begin
            if (o == start + 13'(i)) begin
                r[i*8 +: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gpthv_accum.sv =====
// gpthv_accum: byte-wise field capture and header crc for the gpt header validator
// depends on gpthv_pkg and gpt_header_validator_defines.svh
`timescale 1ns / 1ps
`include "gpt_header_validator_defines.svh"

module gpthv_accum #(
    parameter int BLOCK_BYTES = gpthv_pkg::BLOCK_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gpthv_pkg::gpthv_in_t   in_data,
    output logic                   snap_vld,
    input  logic                   snap_take,
    output gpthv_pkg::gpthv_snap_t snap
);
    import gpthv_pkg::*;

    localparam logic [OFFSET_W-1:0] BLOCK_LIM = OFFSET_W'(BLOCK_BYTES);

    logic                fire;
    logic                in_block;
    logic                crc_en;
    logic [7:0]          crc_in;
    logic [12:0]         offset_reg, offset_next;
    logic [31:0]         crc_reg;
    gpthv_snap_t         fld_reg, fld_next;
    gpthv_snap_t         snap_reg;
    logic                snap_vld_reg, snap_vld_next;

    // a new item is taken unless a verdict is still parked in the snapshot and not being taken
    assign in_ready = !snap_vld_reg || snap_take;
    assign fire     = in_valid && in_ready;

    // field capture and crc update for the current byte
    always_comb
    begin
        fld_next = fld_reg;
        in_block = offset_reg < BLOCK_LIM;
        crc_en   = (offset_reg < OFS_HDR_CRC) || ({19'd0, offset_reg} < fld_reg.hdr_size);
        crc_in   = (offset_reg >= OFS_HDR_CRC && offset_reg < OFS_CRC_END) ? 8'd0
                                                                           : in_data.data_byte;
        fld_next.calc_crc = crc_reg;
        if (in_block)
        begin
            fld_next.signature = put64(fld_reg.signature, offset_reg, OFS_SIG, in_data.data_byte);
            fld_next.hdr_size  = put32(fld_reg.hdr_size, offset_reg, OFS_HDR_SIZE,
                                       in_data.data_byte);
            fld_next.hdr_crc   = put32(fld_reg.hdr_crc, offset_reg, OFS_HDR_CRC,
                                       in_data.data_byte);
            fld_next.my_lba    = put64(fld_reg.my_lba, offset_reg, OFS_MY_LBA, in_data.data_byte);
            fld_next.alt_lba   = put64(fld_reg.alt_lba, offset_reg, OFS_ALT_LBA,
                                       in_data.data_byte);
            fld_next.first_lba = put64(fld_reg.first_lba, offset_reg, OFS_FIRST_LBA,
                                       in_data.data_byte);
            fld_next.last_lba  = put64(fld_reg.last_lba, offset_reg, OFS_LAST_LBA,
                                       in_data.data_byte);
            fld_next.ent_lba   = put64(fld_reg.ent_lba, offset_reg, OFS_ENT_LBA,
                                       in_data.data_byte);
            fld_next.ent_count = put32(fld_reg.ent_count, offset_reg, OFS_ENT_CNT,
                                       in_data.data_byte);
            fld_next.ent_size  = put32(fld_reg.ent_size, offset_reg, OFS_ENT_SIZE,
                                       in_data.data_byte);
            fld_next.ent_crc   = put32(fld_reg.ent_crc, offset_reg, OFS_ENT_CRC,
                                       in_data.data_byte);
            if (crc_en)
            begin
                fld_next.calc_crc = crc32_byte(crc_reg, crc_in);
            end
        end
        // counter saturates so a runaway block cannot wrap
        offset_next = (offset_reg < OFFSET_MAX) ? offset_reg + 13'd1 : offset_reg;
        fld_next.byte_count = offset_next;
    end

    // snapshot handshake toward the checker
    always_comb
    begin
        snap_vld_next = snap_vld_reg;
        if (fire && in_data.last_byte)
        begin
            snap_vld_next = 1'b1;
        end
        else if (snap_take)
        begin
            snap_vld_next = 1'b0;
        end
    end

    // per-block state, cleared on the last byte of every block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            crc_reg      <= CRC_INIT;
            fld_reg      <= '0;
            snap_vld_reg <= 1'b0;
        end
        else
        begin
            snap_vld_reg <= snap_vld_next;
            if (fire)
            begin
                if (in_data.last_byte)
                begin
                    offset_reg <= '0;
                    crc_reg    <= CRC_INIT;
                    fld_reg    <= '0;
                end
                else
                begin
                    offset_reg <= offset_next;
                    crc_reg    <= fld_next.calc_crc;
                    fld_reg    <= fld_next;
                end
            end
        end
    end

    // frozen copy of the finished header
    always_ff @(posedge clk)
    begin
        if (fire && in_data.last_byte)
        begin
            snap_reg <= fld_next;
        end
    end

    assign snap_vld = snap_vld_reg;
    assign snap     = snap_reg;

    `GPTHV_ASSERT_NXT(a_clear_after_last, fire && in_data.last_byte, offset_reg == '0 && crc_reg == CRC_INIT)
    `GPTHV_ASSERT_IMP(a_stall_only_when_full, !in_ready, snap_vld_reg)

endmodule

// ===== hw/rtl/gpthv_check.sv =====
// gpthv_check: configuration registers, header checks and result register
// depends on gpthv_pkg and gpt_header_validator_defines.svh
`timescale 1ns / 1ps
`include "gpt_header_validator_defines.svh"

module gpthv_check #(
    parameter int BLOCK_BYTES = gpthv_pkg::BLOCK_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_idx,
    input  logic [63:0]            cfg_data,
    input  logic                   snap_vld,
    output logic                   snap_take,
    input  gpthv_pkg::gpthv_snap_t snap,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gpthv_pkg::gpthv_out_t  out_data
);
    import gpthv_pkg::*;

    localparam logic [31:0] MAX_HDR_SIZE = 32'(BLOCK_BYTES);

    logic [63:0] header_lba_reg;
    logic [63:0] disk_last_lba_reg;
    logic        sig_bad;
    logic        crc_bad;
    logic [2:0]  code;
    gpthv_out_t  res;
    gpthv_out_t  out_reg;
    logic        out_vld_reg, out_vld_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_lba_reg    <= 64'd1;
            disk_last_lba_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_HEADER_LBA:    header_lba_reg    <= cfg_data;
                CFG_DISK_LAST_LBA: disk_last_lba_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // checks in priority order, first failure wins
    always_comb
    begin
        sig_bad = snap.signature != SIG_EFI_PART;
        crc_bad = (snap.hdr_size < MIN_HDR_SIZE) || (snap.hdr_size > MAX_HDR_SIZE) ||
                  ({19'd0, snap.byte_count} < snap.hdr_size) ||
                  ((snap.calc_crc ^ CRC_INIT) != snap.hdr_crc);
        if (sig_bad)
            code = ERR_SIGNATURE;
        else if (crc_bad)
            code = ERR_CRC_SIZE;
        else if (snap.my_lba != header_lba_reg)
            code = ERR_MY_LBA;
        else if (snap.first_lba > disk_last_lba_reg)
            code = ERR_FIRST_LBA;
        else if (snap.last_lba > disk_last_lba_reg)
            code = ERR_LAST_LBA;
        else if (snap.ent_lba > disk_last_lba_reg)
            code = ERR_ENTRY_LBA;
        else
            code = ERR_OK;

        res.header_ok       = code == ERR_OK;
        res.error_code      = code;
        res.alt_hdr_lba     = snap.alt_lba;
        res.first_use_lba   = snap.first_lba;
        res.last_use_lba    = snap.last_lba;
        res.entry_array_lba = snap.ent_lba;
        res.entry_count     = snap.ent_count;
        res.entry_size      = snap.ent_size;
        res.entry_array_crc = snap.ent_crc;
    end

    // result register moves when empty or being drained
    assign snap_take = snap_vld && (!out_vld_reg || out_ready);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (snap_take)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
            out_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `GPTHV_ASSERT_IMP(a_ok_matches_code, out_vld_reg, out_reg.header_ok == (out_reg.error_code == ERR_OK))
    `GPTHV_ASSERT_NXT(a_take_fills_output, snap_take, out_vld_reg)

endmodule

// ===== hw/rtl/gpt_header_validator.sv =====
// gpt_header_validator: top level of the gpt header validator
// depends on gpthv_pkg, gpthv_accum and gpthv_check
`timescale 1ns / 1ps

// Usage
//   in channel: one header byte per item (data_byte, offset zero first),
//     last_byte set on the final byte of the block. Only the last item of a
//     block yields a result item; all other items yield none.
//   out channel: one verdict per block: header_ok, error_code and the
//     captured header fields.
//   cfg port: cfg_we / cfg_idx / cfg_data write header_lba (index 0) and
//     disk_last_lba (index 1); write only while the block is idle.
//   Throughput: one byte per cycle while in_ready is high, set by the byte-wide
//     crc-32 update and field capture done in the cycle the byte is accepted.
//   Path: the fields of a block are frozen in the snapshot register when its
//     last byte is accepted; the verdict then goes into the result register.
//   Stalls: bytes of the next block keep flowing while a result waits; input
//     stops only when both the snapshot and the result register are full.
//   Reset: all per-block state cleared, crc preset to all ones, header_lba
//     set to 1 and disk_last_lba to 0; no results pending.
module gpt_header_validator #(
    parameter int BLOCK_BYTES = gpthv_pkg::BLOCK_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpthv_pkg::gpthv_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpthv_pkg::gpthv_out_t out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_idx,
    input  logic [63:0]           cfg_data
);
    import gpthv_pkg::*;

    logic        snap_vld;
    logic        snap_take;
    gpthv_snap_t snap;

    // byte capture and crc
    gpthv_accum #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .snap_vld  (snap_vld),
        .snap_take (snap_take),
        .snap      (snap)
    );

    // verdict and result register
    gpthv_check #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .snap_vld  (snap_vld),
        .snap_take (snap_take),
        .snap      (snap),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
